// ----- rtl/hpsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap page swap policy package
// Shared constants, payload structs, result codes and sequencer states.
// ----------------------------------------------------------------------------
package hpsp_pkg;

	localparam int HEAP_ENTRIES_DEF    = 1024;
	localparam int SWAP_BLOCKS_DEF     = 1024;
	localparam int BLOCKS_PER_PAGE_DEF = 4;

	localparam logic [31:0] WINDOW_RESET  = 32'd50;
	localparam logic [10:0] MAX_RES_RESET = 11'd100;
	localparam logic [10:0] COUNT_MAX     = 11'd2047;

	typedef logic [2:0] outcome_t;
	localparam outcome_t OC_REGISTERED = 3'd0;
	localparam outcome_t OC_NOT_HEAP   = 3'd1;
	localparam outcome_t OC_FRESH      = 3'd2;
	localparam outcome_t OC_SWAP_LOAD  = 3'd3;
	localparam outcome_t OC_ERROR      = 3'd4;

	localparam logic MODE_REGISTER = 1'b0;

	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_MAX_RES = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [26:0] page_number;
		logic [31:0] now_ticks;
	} in_item_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [9:0]  entry_index;
		logic        evicted;
		logic [26:0] victim_page;
		logic [9:0]  victim_block;
		logic [9:0]  load_block;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic loaded;
		logic in_swap;
	} flags_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DECIDE,
		ST_W1,
		ST_W2,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/hpsp_ram.sv -----
// ----------------------------------------------------------------------------
// Heap page swap policy RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hpsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/heap_page_swap_policy_top.sv -----
// ----------------------------------------------------------------------------
// Heap page swap policy
// Heap page tracker with working-set replacement and oldest-first fallback.
// ----------------------------------------------------------------------------
// Input items (in_valid/in_ready/in_data) either register a heap page or
// report a page fault with the current tick count. Each item produces one
// result transfer on out_valid/out_ready/out_data. The two registers must be written
// via cfg_we/cfg_index/cfg_data only while the block is idle (unenforced).
//
// One item is handled at a time. Every item sweeps the tracker and the swap
// group map once through their RAM read ports, one entry per cycle. The
// result then passes the LAST, DECIDE, W2 and DONE states, with a victim
// write state W1 before W2 when a victim is evicted, and the next item can
// be accepted in the cycle after the result is loaded. The sweep sets the
// item rate.
//
// After reset the block clears its flag and swap group RAMs, one entry per
// cycle, with in_ready low. A result that is not taken waits in the output
// register; the next item may still be accepted and is held finished until
// the output register frees up.
// ----------------------------------------------------------------------------
module heap_page_swap_policy_top
	import hpsp_pkg::*;
#(
	parameter int HEAP_ENTRIES    = HEAP_ENTRIES_DEF,
	parameter int SWAP_BLOCKS     = SWAP_BLOCKS_DEF,
	parameter int BLOCKS_PER_PAGE = BLOCKS_PER_PAGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NG     = SWAP_BLOCKS / BLOCKS_PER_PAGE;
	localparam int NGR    = (NG < 2) ? 2 : NG;
	localparam int EW     = $clog2(HEAP_ENTRIES);
	localparam int GW     = $clog2(NGR);
	localparam int SCAN_N = (HEAP_ENTRIES > NGR) ? HEAP_ENTRIES : NGR;
	localparam int CW     = $clog2(SCAN_N);

	typedef struct packed {
		logic [26:0]   page;
		logic [GW-1:0] grp;
		logic [31:0]   ltime;
	} edata_t;

	state_t state_q, state_d;

	logic [31:0] window_q;
	logic [10:0] max_res_q;
	logic [10:0] res_cnt_q;

	in_item_t item_q;
	logic [CW-1:0] addr_q;

	logic          scan_vld_s1;
	logic          ent_ok_s1;
	logic          grp_ok_s1;
	logic [CW-1:0] idx_s1;

	logic          found_q;
	logic [EW-1:0] e_idx_q;
	flags_t        e_flags_q;
	logic [GW-1:0] e_grp_q;
	logic          free_found_q;
	logic [EW-1:0] free_idx_q;
	logic          g_found_q;
	logic [GW-1:0] g_idx_q;
	logic          b1_found_q;
	logic [EW-1:0] b1_idx_q;
	logic [26:0]   b1_page_q;
	logic [31:0]   b1_time_q;
	logic          b2_found_q;
	logic [EW-1:0] b2_idx_q;
	logic [26:0]   b2_page_q;
	logic [31:0]   b2_time_q;

	logic          w_addr_sel_free_q;
	logic          w_flags_we_q;
	flags_t        w_flags_q;
	logic          w_data_we_q;
	edata_t        w_data_q;
	logic          w_grp_we_q;

	out_item_t res_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic   fl_we, dt_we, gr_we;
	logic [EW-1:0] fl_waddr, ent_raddr;
	flags_t fl_wdata, fl_rdata;
	edata_t dt_wdata, dt_rdata;
	logic [GW-1:0] gr_waddr, gr_raddr;
	logic   gr_wdata, gr_rdata;

	logic addr_ent_ok, addr_grp_ok, addr_last;
	logic in_fire, out_fire, out_load;

	logic [EW-1:0] v_idx;
	logic [26:0]   v_page;
	logic [31:0]   v_time;
	logic          need_evict, evict_ok;
	logic [31:0]   idle_ticks;
	logic          is_idle;

	assign addr_ent_ok = ({1'b0, addr_q} < (CW + 1)'(HEAP_ENTRIES));
	assign addr_grp_ok = ({1'b0, addr_q} < (CW + 1)'(NG));
	assign addr_last   = (addr_q == CW'(SCAN_N - 1));
	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign out_fire    = out_valid_q && out_ready;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	assign ent_raddr = addr_q[EW-1:0];
	assign gr_raddr  = addr_q[GW-1:0];

	assign v_idx  = b1_found_q ? b1_idx_q  : b2_idx_q;
	assign v_page = b1_found_q ? b1_page_q : b2_page_q;
	assign v_time = b1_found_q ? b1_time_q : b2_time_q;
	assign need_evict = (res_cnt_q >= max_res_q);
	assign evict_ok   = g_found_q && (b1_found_q || b2_found_q);

	assign idle_ticks = item_q.now_ticks - dt_rdata.ltime;
	assign is_idle    = (idle_ticks > window_q);

	hpsp_ram #(.WIDTH($bits(flags_t)), .DEPTH(HEAP_ENTRIES)) u_flags (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (ent_raddr),
		.rdata (fl_rdata)
	);

	hpsp_ram #(.WIDTH($bits(edata_t)), .DEPTH(HEAP_ENTRIES)) u_data (
		.clk   (clk),
		.we    (dt_we),
		.waddr (fl_waddr),
		.wdata (dt_wdata),
		.raddr (ent_raddr),
		.rdata (dt_rdata)
	);

	hpsp_ram #(.WIDTH(1), .DEPTH(NGR)) u_groups (
		.clk   (clk),
		.we    (gr_we),
		.waddr (gr_waddr),
		.wdata (gr_wdata),
		.raddr (gr_raddr),
		.rdata (gr_rdata)
	);

	// RAM write ports: clearing pass, victim writes, then faulting or newly registered entry writes.
	always_comb begin
		fl_we    = 1'b0;
		dt_we    = 1'b0;
		gr_we    = 1'b0;
		fl_waddr = addr_q[EW-1:0];
		fl_wdata = '0;
		dt_wdata = w_data_q;
		gr_waddr = addr_q[GW-1:0];
		gr_wdata = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				fl_we = addr_ent_ok;
				gr_we = addr_grp_ok;
			end
			ST_W1: begin
				fl_we    = 1'b1;
				dt_we    = 1'b1;
				gr_we    = 1'b1;
				fl_waddr = v_idx;
				fl_wdata = '{valid: 1'b1, loaded: 1'b0, in_swap: 1'b1};
				dt_wdata = '{page: v_page, grp: g_idx_q, ltime: v_time};
				gr_waddr = g_idx_q;
				gr_wdata = 1'b1;
			end
			ST_W2: begin
				fl_we    = w_flags_we_q;
				dt_we    = w_data_we_q;
				gr_we    = w_grp_we_q;
				fl_waddr = w_addr_sel_free_q ? free_idx_q : e_idx_q;
				fl_wdata = w_flags_q;
				gr_waddr = e_grp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (addr_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_fire) state_d = ST_SCAN;
			ST_SCAN:   if (addr_last) state_d = ST_LAST;
			ST_LAST:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (item_q.mode != MODE_REGISTER && found_q && !e_flags_q.loaded &&
				    need_evict && evict_ok) begin
					state_d = ST_W1;
				end else begin
					state_d = ST_W2;
				end
			end
			ST_W1:     state_d = ST_W2;
			ST_W2:     state_d = ST_DONE;
			ST_DONE:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			max_res_q <= MAX_RES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW:  window_q  <= cfg_data;
				CFG_MAX_RES: max_res_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			res_cnt_q   <= '0;
		end else begin
			if ((state_q == ST_CLEAR || state_q == ST_SCAN) && !addr_last) begin
				addr_q <= addr_q + 1'b1;
			end else begin
				addr_q <= '0;
			end
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DECIDE && item_q.mode != MODE_REGISTER && found_q &&
			    !e_flags_q.loaded && (!need_evict || evict_ok)) begin
				if (need_evict && res_cnt_q != '0) begin
					res_cnt_q <= res_cnt_q;
				end else if (res_cnt_q < COUNT_MAX) begin
					res_cnt_q <= res_cnt_q + 1'b1;
				end
			end
		end
	end

	// Scan trackers and result planning. The read issued for address addr_q
	// returns in the next cycle, tagged by the _s1 stage.
	always_ff @(posedge clk) begin
		idx_s1    <= addr_q;
		ent_ok_s1 <= addr_ent_ok;
		grp_ok_s1 <= addr_grp_ok;
		if (out_load) begin
			out_q <= res_q;
		end
		if (in_fire) begin
			item_q       <= in_data;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			g_found_q    <= 1'b0;
			b1_found_q   <= 1'b0;
			b2_found_q   <= 1'b0;
		end else if (scan_vld_s1) begin
			if (ent_ok_s1 && fl_rdata.valid && !found_q &&
			    dt_rdata.page == item_q.page_number) begin
				found_q   <= 1'b1;
				e_idx_q   <= idx_s1[EW-1:0];
				e_flags_q <= fl_rdata;
				e_grp_q   <= dt_rdata.grp;
			end
			if (ent_ok_s1 && !fl_rdata.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1[EW-1:0];
			end
			if (grp_ok_s1 && !gr_rdata && !g_found_q) begin
				g_found_q <= 1'b1;
				g_idx_q   <= idx_s1[GW-1:0];
			end
			if (ent_ok_s1 && fl_rdata.loaded) begin
				if (is_idle && (!b1_found_q || dt_rdata.ltime < b1_time_q)) begin
					b1_found_q <= 1'b1;
					b1_idx_q   <= idx_s1[EW-1:0];
					b1_page_q  <= dt_rdata.page;
					b1_time_q  <= dt_rdata.ltime;
				end
				if (!b2_found_q || dt_rdata.ltime < b2_time_q) begin
					b2_found_q <= 1'b1;
					b2_idx_q   <= idx_s1[EW-1:0];
					b2_page_q  <= dt_rdata.page;
					b2_time_q  <= dt_rdata.ltime;
				end
			end
		end
		if (state_q == ST_DECIDE) begin
			res_q             <= '0;
			w_addr_sel_free_q <= 1'b0;
			w_flags_we_q      <= 1'b0;
			w_data_we_q       <= 1'b0;
			w_grp_we_q        <= 1'b0;
			w_flags_q         <= '{valid: 1'b1, loaded: 1'b1, in_swap: 1'b0};
			w_data_q          <= '{page: item_q.page_number, grp: e_grp_q,
			                       ltime: item_q.now_ticks};
			if (item_q.mode == MODE_REGISTER) begin
				if (found_q) begin
					res_q.entry_index <= 10'(e_idx_q);
				end else if (free_found_q) begin
					res_q.entry_index <= 10'(free_idx_q);
					w_addr_sel_free_q <= 1'b1;
					w_flags_we_q      <= 1'b1;
					w_data_we_q       <= 1'b1;
					w_flags_q         <= '{valid: 1'b1, loaded: 1'b0, in_swap: 1'b0};
					w_data_q          <= '{page: item_q.page_number, grp: '0, ltime: '0};
				end else begin
					res_q.outcome <= OC_ERROR;
				end
			end else if (!found_q) begin
				res_q.outcome <= OC_NOT_HEAP;
			end else if (e_flags_q.loaded) begin
				res_q.outcome     <= OC_FRESH;
				res_q.entry_index <= 10'(e_idx_q);
				w_data_we_q       <= 1'b1;
			end else if (need_evict && !evict_ok) begin
				res_q.outcome     <= OC_ERROR;
				res_q.entry_index <= 10'(e_idx_q);
			end else begin
				res_q.outcome     <= e_flags_q.in_swap ? OC_SWAP_LOAD : OC_FRESH;
				res_q.entry_index <= 10'(e_idx_q);
				w_flags_we_q      <= 1'b1;
				w_data_we_q       <= 1'b1;
				w_grp_we_q        <= e_flags_q.in_swap;
				if (e_flags_q.in_swap) begin
					res_q.load_block <= 10'(32'(e_grp_q) * 32'(BLOCKS_PER_PAGE));
				end
				if (need_evict) begin
					res_q.evicted      <= 1'b1;
					res_q.victim_page  <= v_page;
					res_q.victim_block <= 10'(32'(g_idx_q) * 32'(BLOCKS_PER_PAGE));
				end
			end
		end
	end

	// The victim write needs a free group and a loaded page to exist.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_W1 |-> g_found_q && (b1_found_q || b2_found_q))
		else $error("victim write without a free group or a victim");

	// An accepted item always starts a tracker sweep in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_SCAN)
		else $error("accepted item did not start a sweep");

	// The resident count moves only when a fault is resolved.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DECIDE |=> $stable(res_cnt_q))
		else $error("resident count changed outside fault resolution");

	// A finished result is loaded only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ready)
		else $error("result overwrote a pending transfer");

endmodule
